### hdl/voxel_series_variance_assert.svh
// Assertion macros for the voxel series variance block.
// Included by the top level; no other dependencies.
`ifndef VOXEL_SERIES_VARIANCE_ASSERT_SVH
`define VOXEL_SERIES_VARIANCE_ASSERT_SVH
`ifndef SYNTHESIS
`define VSV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define VSV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VSV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define VSV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/vsv_pkg.sv
// Shared types and constants for the voxel series variance block.
// No dependencies.
package vsv_pkg;

    localparam int MAX_FRAMES  = 4096;
    localparam int MAX_RUNS    = 64;
    localparam int ADDR_W      = $clog2(MAX_FRAMES);
    localparam int TAG_W       = $clog2(MAX_RUNS);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int RUN_W       = TAG_W + 1;
    localparam int SUM_W       = 48;
    localparam int MEAN_W      = 33;
    localparam int VAL_W       = 48;
    localparam int DIV_STEPS   = 64;
    localparam int SQRT_STEPS  = 40;

    localparam logic [VAL_W-1:0] POS_LIM = 48'h7fff_ffff_ffff;
    localparam logic [VAL_W-1:0] NEG_LIM = 48'h8000_0000_0000;
    localparam logic [VAL_W-1:0] ONE_Q16 = 48'h0000_0001_0000;
    localparam logic [1:0] FILL_MODE_KEEP = 2'd3;

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_GLOBAL = 2'd1,
        REG_FILL   = 2'd2,
        REG_GAIN   = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_VAR     = 2'd0,
        MODE_STD     = 2'd1,
        MODE_MASK    = 2'd2,
        MODE_VAR_ALT = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        FILL_NONE = 2'd0,
        FILL_ZERO = 2'd1,
        FILL_TINY = 2'd2,
        FILL_NAN  = 2'd3
    } fill_code_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_GMEAN_WAIT,
        ST_RUN_RD,
        ST_RUN_DIV,
        ST_RUN_WAIT,
        ST_PASS,
        ST_VAR,
        ST_VAR_WAIT,
        ST_ROOT_CHK,
        ST_SQRT,
        ST_GAIN_LO,
        ST_GAIN_HI,
        ST_FINISH
    } back_state_t;

    typedef struct packed {
        logic                     en;
        logic [ADDR_W-1:0]        addr;
        logic signed [31:0]       sample;
        logic [TAG_W-1:0]         tag;
    } store_wr_t;

    typedef struct packed {
        logic                     en;
        logic [TAG_W-1:0]         tag;
        logic signed [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]         count;
    } run_wr_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]  total;
        logic [CNT_W-1:0]         count;
        logic [RUN_W-1:0]         runs;
        logic                     valid;
    } job_t;

    typedef struct packed {
        logic [1:0]               mode;
        logic                     global_mean;
        logic [1:0]               fill_mode;
        logic signed [31:0]       gain;
    } cfg_t;

endpackage

### hdl/vsv_front.sv
// Front end: takes frames, tracks runs and sums, writes the sample store.
// Depends on vsv_pkg.
module vsv_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic signed [31:0]   sample,
    input  logic                 undefined,
    input  logic                 counted,
    input  logic                 run_start,
    input  logic                 last,
    output vsv_pkg::store_wr_t   store_wr,
    output vsv_pkg::run_wr_t     run_wr,
    output logic                 job_push,
    output vsv_pkg::job_t        job,
    output logic                 flushing
);
    import vsv_pkg::*;

    logic [RUN_W-1:0]        rn_reg, rn_next;
    logic [CNT_W-1:0]        sc_reg, sc_next;
    logic signed [SUM_W-1:0] total_reg, total_next;
    logic signed [SUM_W-1:0] cur_sum_reg, cur_sum_next;
    logic [CNT_W-1:0]        cur_cnt_reg, cur_cnt_next;
    logic                    valid_reg, valid_next;
    logic                    flush_reg, flush_next;

    logic                    open_run;
    logic [RUN_W-1:0]        rn_new;
    logic [TAG_W-1:0]        tag;
    logic                    store_ok;
    logic signed [SUM_W-1:0] samp_ext;
    logic signed [SUM_W-1:0] base_sum;
    logic [CNT_W-1:0]        base_cnt;

    always_comb
    begin
        open_run = (run_start || rn_reg == '0) && (rn_reg < RUN_W'(MAX_RUNS));
        rn_new   = rn_reg + RUN_W'(open_run);
        tag      = TAG_W'(rn_new - RUN_W'(1));
        store_ok = counted && (sc_reg < CNT_W'(MAX_FRAMES));
        samp_ext = SUM_W'(sample);
        base_sum = open_run ? '0 : cur_sum_reg;
        base_cnt = open_run ? '0 : cur_cnt_reg;

        rn_next      = rn_reg;
        sc_next      = sc_reg;
        total_next   = total_reg;
        cur_sum_next = cur_sum_reg;
        cur_cnt_next = cur_cnt_reg;
        valid_next   = valid_reg;
        flush_next   = flush_reg;

        store_wr.en     = accept && store_ok;
        store_wr.addr   = sc_reg[ADDR_W-1:0];
        store_wr.sample = sample;
        store_wr.tag    = tag;

        run_wr.en    = 1'b0;
        run_wr.tag   = TAG_W'(rn_reg - RUN_W'(1));
        run_wr.sum   = cur_sum_reg;
        run_wr.count = cur_cnt_reg;

        job_push  = flush_reg;
        job.total = total_reg;
        job.count = sc_reg;
        job.runs  = rn_reg;
        job.valid = valid_reg;

        if (flush_reg)
        begin
            // The last run goes to the run table, then per-voxel state clears.
            run_wr.en    = 1'b1;
            rn_next      = '0;
            sc_next      = '0;
            total_next   = '0;
            cur_sum_next = '0;
            cur_cnt_next = '0;
            valid_next   = 1'b1;
            flush_next   = 1'b0;
        end
        else if (accept)
        begin
            run_wr.en    = open_run && (rn_reg != '0);
            rn_next      = rn_new;
            cur_sum_next = base_sum;
            cur_cnt_next = base_cnt;
            if (counted && (undefined || sample == '0))
                valid_next = 1'b0;
            if (store_ok)
            begin
                cur_sum_next = base_sum + samp_ext;
                cur_cnt_next = base_cnt + CNT_W'(1);
                total_next   = total_reg + samp_ext;
                sc_next      = sc_reg + CNT_W'(1);
            end
            flush_next = last;
        end
    end

    assign flushing = flush_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rn_reg      <= '0;
            sc_reg      <= '0;
            total_reg   <= '0;
            cur_sum_reg <= '0;
            cur_cnt_reg <= '0;
            valid_reg   <= 1'b1;
            flush_reg   <= 1'b0;
        end
        else
        begin
            rn_reg      <= rn_next;
            sc_reg      <= sc_next;
            total_reg   <= total_next;
            cur_sum_reg <= cur_sum_next;
            cur_cnt_reg <= cur_cnt_next;
            valid_reg   <= valid_next;
            flush_reg   <= flush_next;
        end
    end

endmodule

### hdl/vsv_fifo.sv
// Two-entry queue of voxel jobs between the front and back ends.
// Depends on vsv_pkg.
module vsv_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  vsv_pkg::job_t  push_data,
    input  logic           pop,
    output logic           not_empty,
    output vsv_pkg::job_t  pop_data
);
    import vsv_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    always_comb
    begin
        do_push     = push && (cnt_reg != 2'd2);
        do_pop      = pop && (cnt_reg != 2'd0);
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### hdl/vsv_div.sv
// Restoring divider, one quotient bit a cycle, quotient rounded to nearest.
// Depends on vsv_pkg.
module vsv_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [63:0]                num,
    input  logic [vsv_pkg::CNT_W-1:0]  den,
    output logic                       done,
    output logic [63:0]                quot
);
    import vsv_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS + 1);

    logic               active_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [63:0]        num_reg;
    logic [63:0]        q_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   den_reg;

    logic [CNT_W:0]     rem_sh;
    logic               fits;
    logic [CNT_W:0]     rem_dif;
    logic               round_up;

    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[63]};
        fits     = rem_sh >= {1'b0, den_reg};
        rem_dif  = rem_sh - {1'b0, den_reg};
        round_up = {rem_reg, 1'b0} >= {1'b0, den_reg};
    end

    assign done = done_reg;
    assign quot = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!active_reg && start)
            begin
                active_reg <= 1'b1;
                step_reg   <= '0;
            end
            else if (active_reg)
            begin
                if (step_reg == STEP_W'(DIV_STEPS))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
                else
                    step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!active_reg && start)
        begin
            num_reg <= num;
            den_reg <= den;
            q_reg   <= '0;
            rem_reg <= '0;
        end
        else if (active_reg)
        begin
            if (step_reg == STEP_W'(DIV_STEPS))
                q_reg <= q_reg + 64'(round_up);
            else
            begin
                num_reg <= {num_reg[62:0], 1'b0};
                q_reg   <= {q_reg[62:0], fits};
                rem_reg <= fits ? rem_dif[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            end
        end
    end

endmodule

### hdl/vsv_back.sv
// Back end: run or global means, deviation pass, variance, root, gain, mask and fill.
// Holds the sample, run and mean stores; depends on vsv_pkg and vsv_div.
module vsv_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  vsv_pkg::cfg_t           cfg,
    input  logic                    job_valid,
    input  vsv_pkg::job_t           job,
    output logic                    job_pop,
    input  vsv_pkg::store_wr_t      store_wr,
    input  vsv_pkg::run_wr_t        run_wr,
    output logic                    active,
    output logic                    done,
    output logic signed [47:0]      value,
    output logic [1:0]              fill_code
);
    import vsv_pkg::*;

    localparam int K_W = $clog2(SQRT_STEPS + 1);

    // Stores
    logic signed [31:0]        samp_mem [MAX_FRAMES];
    logic [TAG_W-1:0]          tag_mem  [MAX_FRAMES];
    logic signed [SUM_W-1:0]   rsum_mem [MAX_RUNS];
    logic [CNT_W-1:0]          rcnt_mem [MAX_RUNS];
    logic signed [MEAN_W-1:0]  mean_mem [MAX_RUNS];

    back_state_t state_reg, state_next;

    job_t                      job_reg;
    logic signed [MEAN_W-1:0]  gmean_reg;
    logic [RUN_W-1:0]          r_reg;
    logic [CNT_W-1:0]          i_reg;
    logic signed [SUM_W-1:0]   rs_q;
    logic [CNT_W-1:0]          rc_q;
    logic signed [31:0]        samp_q, samp2_reg;
    logic [TAG_W-1:0]          tag_q;
    logic signed [MEAN_W-1:0]  mean_q;
    logic [31:0]               mag_reg;
    logic [63:0]               sq_reg;
    logic [63:0]               dev_reg;
    logic [63:0]               var_reg;
    logic [79:0]               vsh_reg;
    logic [40:0]               root_reg;
    logic [42:0]               rem_reg;
    logic [K_W-1:0]            k_reg;
    logic [63:0]               p1_reg, p2_reg;
    logic                      v1_reg, v2_reg, v3_reg, v4_reg;
    logic                      done_reg;
    logic signed [47:0]        value_reg;
    logic [1:0]                fill_reg;

    // Divider hook-up
    logic                      div_start;
    logic [63:0]               div_num;
    logic [CNT_W-1:0]          div_den;
    logic                      div_done;
    logic [63:0]               div_quot;

    vsv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Combinational helpers
    logic [SUM_W-1:0]          total_mag, rsum_mag;
    logic [MEAN_W-1:0]         quot_lo;
    logic signed [MEAN_W-1:0]  gmean_new, rmean_new;
    logic                      issue;
    logic                      pass_end;
    logic                      last_run;
    logic signed [33:0]        diff;
    logic [33:0]               diff_mag;
    logic [48:0]               sq_term;
    logic [64:0]               dev_sum;
    logic signed [CNT_W:0]     dv;
    logic                      dv_pos;
    logic [44:0]               rem2, sq_test;
    logic                      sq_fit;
    logic                      gneg;
    logic [31:0]               gabs;
    logic [VAL_W-1:0]          lim;
    logic [64:0]               p1_rnd;
    logic [49:0]               r_sum;
    logic [VAL_W-1:0]          r_sat;
    logic [VAL_W-1:0]          gained;
    logic [VAL_W-1:0]          val_out;
    logic [1:0]                code_out;

    always_comb
    begin
        total_mag = job_reg.total[SUM_W-1] ? SUM_W'(-job_reg.total) : job_reg.total;
        rsum_mag  = rs_q[SUM_W-1] ? SUM_W'(-rs_q) : rs_q;
        quot_lo   = div_quot[MEAN_W-1:0];
        gmean_new = job_reg.total[SUM_W-1] ? -$signed(quot_lo) : $signed(quot_lo);
        rmean_new = rs_q[SUM_W-1] ? -$signed(quot_lo) : $signed(quot_lo);

        issue    = (state_reg == ST_PASS) && (i_reg < job_reg.count);
        pass_end = (state_reg == ST_PASS) && (i_reg == job_reg.count)
                   && !v1_reg && !v2_reg && !v3_reg && !v4_reg;
        last_run = (r_reg + RUN_W'(1)) == job_reg.runs;

        diff     = 34'(samp2_reg) - 34'(cfg.global_mean ? gmean_reg : mean_q);
        diff_mag = diff[33] ? 34'(-diff) : 34'(diff);
        sq_term  = 49'(sq_reg[63:16]) + 49'(sq_reg[15]);
        dev_sum  = {1'b0, dev_reg} + 65'(sq_term);

        // Divisor: counted frames, less the runs when means are per run.
        dv     = cfg.global_mean ? $signed({1'b0, job_reg.count})
                                 : $signed({1'b0, job_reg.count})
                                   - $signed((CNT_W+1)'(job_reg.runs));
        dv_pos = !dv[CNT_W] && (dv != '0);

        rem2    = {rem_reg, vsh_reg[79:78]};
        sq_test = {2'b00, root_reg, 2'b01};
        sq_fit  = rem2 >= sq_test;

        gneg   = cfg.gain[31];
        gabs   = gneg ? 32'(-cfg.gain) : 32'(cfg.gain);
        lim    = gneg ? NEG_LIM : POS_LIM;
        p1_rnd = {1'b0, p1_reg} + 65'h8000;
        r_sum  = {p2_reg[33:0], 16'h0000} + 50'(p1_rnd[64:16]);
        if (p2_reg > 64'(lim[VAL_W-1:16]) || r_sum > 50'(lim))
            r_sat = lim;
        else
            r_sat = r_sum[VAL_W-1:0];
        gained = gneg ? VAL_W'(-r_sat) : r_sat;

        if (cfg.mode == MODE_MASK)
        begin
            val_out  = job_reg.valid ? ONE_Q16 : '0;
            code_out = FILL_NONE;
        end
        else if (!job_reg.valid && cfg.fill_mode != FILL_MODE_KEEP)
        begin
            val_out  = '0;
            code_out = cfg.fill_mode + 2'd1;
        end
        else
        begin
            val_out  = gained;
            code_out = FILL_NONE;
        end
    end

    // Next state and divider control
    always_comb
    begin
        state_next = state_reg;
        job_pop    = 1'b0;
        div_start  = 1'b0;
        div_num    = {16'h0000, total_mag};
        div_den    = job_reg.count;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (!cfg.global_mean)
                    state_next = ST_RUN_RD;
                else if (job_reg.count == '0)
                    state_next = ST_PASS;
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_GMEAN_WAIT;
                end
            end
            ST_GMEAN_WAIT:
            begin
                if (div_done)
                    state_next = ST_PASS;
            end
            ST_RUN_RD:
                state_next = ST_RUN_DIV;
            ST_RUN_DIV:
            begin
                div_num = {16'h0000, rsum_mag};
                div_den = rc_q;
                if (rc_q == '0)
                    state_next = last_run ? ST_PASS : ST_RUN_RD;
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_RUN_WAIT;
                end
            end
            ST_RUN_WAIT:
            begin
                if (div_done)
                    state_next = last_run ? ST_PASS : ST_RUN_RD;
            end
            ST_PASS:
            begin
                if (pass_end)
                    state_next = ST_VAR;
            end
            ST_VAR:
            begin
                div_num = dev_reg;
                div_den = dv[CNT_W-1:0];
                if (dv_pos)
                begin
                    div_start  = 1'b1;
                    state_next = ST_VAR_WAIT;
                end
                else
                    state_next = ST_ROOT_CHK;
            end
            ST_VAR_WAIT:
            begin
                if (div_done)
                    state_next = ST_ROOT_CHK;
            end
            ST_ROOT_CHK:
                state_next = (cfg.mode == MODE_STD) ? ST_SQRT : ST_GAIN_LO;
            ST_SQRT:
            begin
                if (k_reg == K_W'(SQRT_STEPS))
                    state_next = ST_GAIN_LO;
            end
            ST_GAIN_LO:
                state_next = ST_GAIN_HI;
            ST_GAIN_HI:
                state_next = ST_FINISH;
            ST_FINISH:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            done_reg  <= (state_reg == ST_FINISH);
        end
    end

    // Store writes and registered reads
    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            samp_mem[store_wr.addr] <= store_wr.sample;
            tag_mem[store_wr.addr]  <= store_wr.tag;
        end
        samp_q <= samp_mem[i_reg[ADDR_W-1:0]];
        tag_q  <= tag_mem[i_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (run_wr.en)
        begin
            rsum_mem[run_wr.tag] <= run_wr.sum;
            rcnt_mem[run_wr.tag] <= run_wr.count;
        end
        rs_q <= rsum_mem[r_reg[TAG_W-1:0]];
        rc_q <= rcnt_mem[r_reg[TAG_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RUN_WAIT && div_done)
            mean_mem[r_reg[TAG_W-1:0]] <= rmean_new;
        else if (state_reg == ST_RUN_DIV && rc_q == '0)
            mean_mem[r_reg[TAG_W-1:0]] <= '0;
        mean_q <= mean_mem[tag_q];
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        samp2_reg <= samp_q;
        mag_reg   <= diff_mag[31:0];
        sq_reg    <= 64'(mag_reg) * 64'(mag_reg);
        if (v4_reg)
            dev_reg <= dev_sum[64] ? {64{1'b1}} : dev_sum[63:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                    job_reg <= job;
                dev_reg <= '0;
                r_reg   <= '0;
                i_reg   <= '0;
            end
            ST_LOAD:
            begin
                if (job_reg.count == '0)
                    gmean_reg <= '0;
            end
            ST_GMEAN_WAIT:
            begin
                if (div_done)
                    gmean_reg <= gmean_new;
            end
            ST_RUN_DIV:
            begin
                if (rc_q == '0)
                    r_reg <= r_reg + RUN_W'(1);
            end
            ST_RUN_WAIT:
            begin
                if (div_done)
                    r_reg <= r_reg + RUN_W'(1);
            end
            ST_PASS:
            begin
                if (issue)
                    i_reg <= i_reg + CNT_W'(1);
            end
            ST_VAR:
            begin
                if (!dv_pos)
                    var_reg <= 64'(POS_LIM);
            end
            ST_VAR_WAIT:
            begin
                if (div_done)
                    var_reg <= div_quot;
            end
            ST_ROOT_CHK:
            begin
                vsh_reg  <= {var_reg, 16'h0000};
                root_reg <= '0;
                rem_reg  <= '0;
                k_reg    <= '0;
            end
            ST_SQRT:
            begin
                if (k_reg == K_W'(SQRT_STEPS))
                    var_reg <= 64'(root_reg) + 64'(rem_reg > {2'b00, root_reg});
                else
                begin
                    rem_reg  <= sq_fit ? 43'(rem2 - sq_test) : rem2[42:0];
                    root_reg <= {root_reg[39:0], sq_fit};
                    vsh_reg  <= {vsh_reg[77:0], 2'b00};
                    k_reg    <= k_reg + K_W'(1);
                end
            end
            ST_GAIN_LO:
                p1_reg <= 64'(var_reg[31:0]) * 64'(gabs);
            ST_GAIN_HI:
                p2_reg <= 64'(var_reg[63:32]) * 64'(gabs);
            ST_FINISH:
            begin
                value_reg <= $signed(val_out);
                fill_reg  <= code_out;
            end
            default:
            begin
            end
        endcase
    end

    assign active    = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign value     = value_reg;
    assign fill_code = fill_reg;

endmodule

### hdl/voxel_series_variance.sv
// Voxel series variance: one frame is taken per cycle while start is high and busy
// is low; a frame marked last makes busy rise until its result is strobed. From the
// last frame to done: flush, job queue, load, per run a read and a divide (one divide
// for the global mean), the deviation pass over the frames, the variance divide, the
// root (std mode only), gain and finish. Reset is asynchronous; it clears control
// state and config registers, but not the sample, run and mean stores or datapath.
module voxel_series_variance (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  sample,
    input  logic                undefined,
    input  logic                counted,
    input  logic                run_start,
    input  logic                last,
    output logic                done,
    output logic signed [47:0]  value,
    output logic [1:0]          fill_code
);
    import vsv_pkg::*;

`include "voxel_series_variance_assert.svh"

    logic [1:0]         mode_reg;
    logic               global_reg;
    logic [1:0]         fill_mode_reg;
    logic signed [31:0] gain_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;
    cfg_t               cfg;

    logic               accept;
    store_wr_t          store_wr;
    run_wr_t            run_wr;
    logic               job_push;
    job_t               job_in;
    job_t               job_out;
    logic               job_pop;
    logic               job_valid;
    logic               flushing;
    logic               back_active;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_VAR;
            global_reg    <= 1'b0;
            fill_mode_reg <= 2'd1;
            gain_reg      <= 32'sh0001_0000;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MODE:   mode_reg      <= pwdata[1:0];
                REG_GLOBAL: global_reg    <= pwdata[0];
                REG_FILL:   fill_mode_reg <= pwdata[1:0];
                REG_GAIN:   gain_reg      <= $signed(pwdata);
                default:    mode_reg      <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_MODE:   prdata = {30'h0, mode_reg};
            REG_GLOBAL: prdata = {31'h0, global_reg};
            REG_FILL:   prdata = {30'h0, fill_mode_reg};
            REG_GAIN:   prdata = gain_reg;
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.mode        = mode_reg;
        cfg.global_mean = global_reg;
        cfg.fill_mode   = fill_mode_reg;
        cfg.gain        = gain_reg;
    end

    assign busy   = flushing || job_valid || back_active;
    assign accept = start && !busy;

    vsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .sample    (sample),
        .undefined (undefined),
        .counted   (counted),
        .run_start (run_start),
        .last      (last),
        .store_wr  (store_wr),
        .run_wr    (run_wr),
        .job_push  (job_push),
        .job       (job_in),
        .flushing  (flushing)
    );

    vsv_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .pop       (job_pop),
        .not_empty (job_valid),
        .pop_data  (job_out)
    );

    vsv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job       (job_out),
        .job_pop   (job_pop),
        .store_wr  (store_wr),
        .run_wr    (run_wr),
        .active    (back_active),
        .done      (done),
        .value     (value),
        .fill_code (fill_code)
    );

    // A last frame that is taken leaves the block busy.
    `VSV_ASSERT_NEXT(a_last_busy, clk, rst_n, accept && last, busy, "last frame not held busy")
    `VSV_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy, "result strobed while still busy")
    `VSV_ASSERT_SAME(a_done_after, clk, rst_n, done, $past(busy), "result without a job")
    `VSV_ASSERT_SAME(a_fill_zero, clk, rst_n, done && (fill_code != FILL_NONE), value == '0,
                     "fill code with a non-zero value")

endmodule
